[hw/rtl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver with Fletcher-8
// check: frame bytes, store sizing, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // largest payload the store holds
    localparam int PAYLOAD_MAX = 64;
    // store address and fill index widths
    localparam int PL_AW = $clog2(PAYLOAD_MAX);
    localparam int WI_W  = $clog2(PAYLOAD_MAX + 1);

    // frame bytes
    localparam logic [7:0] START_FIRST     = 8'hBC;
    localparam logic [7:0] START_SECOND    = 8'hCF;
    localparam logic [7:0] TYPE_RADIO      = 8'h00;
    localparam logic [7:0] TYPE_BATTERY    = 8'h13;
    localparam logic [7:0] BATTERY_MIN_LEN = 8'd5;
    // last payload byte of the voltage word
    localparam logic [PL_AW-1:0] VOLT_LAST_IDX = PL_AW'(4);

    // result kinds
    localparam logic KIND_RADIO   = 1'b0;
    localparam logic KIND_BATTERY = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CKA,
        ST_CKB,
        ST_RAD_RD,
        ST_RAD_OUT,
        ST_BAT_RD,
        ST_BAT_CAP,
        ST_BAT_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ld_type;     // latch type, seed both sums
        logic ld_len;      // latch length, fold, clear fill index
        logic wr_data;     // store payload byte, fold
        logic cnt_inc;     // count a good frame
        logic rd_clr;      // read index to first payload byte
        logic rd_set1;     // read index to second payload byte
        logic rd_issue;    // read the store at the read index
        logic rd_inc;      // advance the read index
        logic volt_shift;  // shift read byte into the voltage word
        logic ld_radio;    // load a payload byte result
        logic ld_battery;  // load the voltage result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_start1;
        logic is_start2;
        logic len_over;
        logic len_zero;
        logic idx_full;
        logic data_done;
        logic eq_sum_a;
        logic eq_sum_b;
        logic go_radio;
        logic go_battery;
        logic rd_last;
        logic volt_done;
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/fpr_ctrl.sv]
// ----------------------------------------------------------------------------
// fpr_ctrl
// Frame parsing and result sequencing state machine. Takes one input item per
// parse step and walks the store when a good frame produces results.
// ----------------------------------------------------------------------------
module fpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  fpr_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output fpr_pkg::t_cmd  o_cmd
);
    import fpr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   parsing;

    // input is taken only in the parse states
    always_comb begin
        unique case (r_state)
            ST_HUNT1, ST_HUNT2, ST_TYPE, ST_LEN,
            ST_DATA, ST_CKA, ST_CKB: parsing = 1'b1;
            default:                 parsing = 1'b0;
        endcase
    end

    assign o_in_stall = !parsing;
    assign in_acc     = i_in_valid && parsing;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT1;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HUNT1: begin
                if (in_acc && i_stat.is_start1) n_state = ST_HUNT2;
            end
            ST_HUNT2: begin
                if (in_acc) n_state = i_stat.is_start2 ? ST_TYPE : ST_HUNT1;
            end
            ST_TYPE: begin
                if (in_acc) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (in_acc) begin
                    if (i_stat.len_over)      n_state = ST_HUNT1;
                    else if (i_stat.len_zero) n_state = ST_CKA;
                    else                      n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (in_acc) begin
                    if (i_stat.idx_full)       n_state = ST_HUNT1;
                    else if (i_stat.data_done) n_state = ST_CKA;
                end
            end
            ST_CKA: begin
                if (in_acc) n_state = i_stat.eq_sum_a ? ST_CKB : ST_HUNT1;
            end
            ST_CKB: begin
                if (in_acc) begin
                    if (i_stat.eq_sum_b && i_stat.go_radio)        n_state = ST_RAD_RD;
                    else if (i_stat.eq_sum_b && i_stat.go_battery) n_state = ST_BAT_RD;
                    else                                           n_state = ST_HUNT1;
                end
            end
            ST_RAD_RD:  n_state = ST_RAD_OUT;
            ST_RAD_OUT: begin
                if (i_stat.out_free) n_state = i_stat.rd_last ? ST_HUNT1 : ST_RAD_RD;
            end
            ST_BAT_RD:  n_state = ST_BAT_CAP;
            ST_BAT_CAP: n_state = i_stat.volt_done ? ST_BAT_OUT : ST_BAT_RD;
            ST_BAT_OUT: begin
                if (i_stat.out_free) n_state = ST_HUNT1;
            end
            default:    n_state = ST_HUNT1;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_TYPE: o_cmd.ld_type = in_acc;
            ST_LEN:  o_cmd.ld_len  = in_acc;
            ST_DATA: o_cmd.wr_data = in_acc && !i_stat.idx_full;
            ST_CKB: begin
                o_cmd.cnt_inc = in_acc && i_stat.eq_sum_b;
                o_cmd.rd_clr  = in_acc && i_stat.eq_sum_b && i_stat.go_radio;
                o_cmd.rd_set1 = in_acc && i_stat.eq_sum_b && !i_stat.go_radio
                                && i_stat.go_battery;
            end
            ST_RAD_RD:  o_cmd.rd_issue = 1'b1;
            ST_RAD_OUT: begin
                o_cmd.ld_radio = i_stat.out_free;
                o_cmd.rd_inc   = i_stat.out_free && !i_stat.rd_last;
            end
            ST_BAT_RD:  o_cmd.rd_issue = 1'b1;
            ST_BAT_CAP: begin
                o_cmd.volt_shift = 1'b1;
                o_cmd.rd_inc     = !i_stat.volt_done;
            end
            ST_BAT_OUT: o_cmd.ld_battery = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

[hw/rtl/fpr_dp.sv]
// ----------------------------------------------------------------------------
// fpr_dp
// Datapath: frame fields, Fletcher-8 sums, payload store, good-frame counter,
// voltage assembly and the output item register.
// ----------------------------------------------------------------------------
module fpr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_out_stall,
    input  fpr_pkg::t_cmd  i_cmd,
    output fpr_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic           o_kind,
    output logic [7:0]     o_data_byte,
    output logic [31:0]    o_voltage_bits,
    output logic           o_last,
    output logic [31:0]    o_good_frames
);
    import fpr_pkg::*;

    logic             r_deliver;
    logic [7:0]       r_type;
    logic [7:0]       r_len;
    logic [7:0]       r_sum_a;
    logic [7:0]       r_sum_b;
    logic [WI_W-1:0]  r_widx;
    logic [PL_AW-1:0] r_ridx;
    logic [7:0]       r_rd_data;
    logic [31:0]      r_volt;
    logic [31:0]      r_count;
    logic [7:0]       r_mem [PAYLOAD_MAX];

    logic             r_o_valid;
    logic             r_o_kind;
    logic [7:0]       r_o_data;
    logic [31:0]      r_o_volt;
    logic             r_o_last;
    logic [31:0]      r_o_count;

    logic [7:0]       fold_a;
    logic [7:0]       widx_nx;
    logic             out_free;

    // running sum A with the current byte folded in
    assign fold_a  = r_sum_a + i_rx_byte;
    assign widx_nx = 8'(r_widx) + 8'd1;
    assign out_free = !r_o_valid || !i_out_stall;

    // status toward the controller
    always_comb begin
        o_stat.is_start1  = (i_rx_byte == START_FIRST);
        o_stat.is_start2  = (i_rx_byte == START_SECOND);
        o_stat.len_over   = ({1'b0, i_rx_byte} > 9'(PAYLOAD_MAX));
        o_stat.len_zero   = (i_rx_byte == 8'd0);
        o_stat.idx_full   = (9'(r_widx) >= 9'(PAYLOAD_MAX));
        o_stat.data_done  = (widx_nx >= r_len);
        o_stat.eq_sum_a   = (i_rx_byte == r_sum_a);
        o_stat.eq_sum_b   = (i_rx_byte == r_sum_b);
        o_stat.go_radio   = (r_type == TYPE_RADIO) && r_deliver && (r_len != 8'd0);
        o_stat.go_battery = (r_type == TYPE_BATTERY) && (r_len >= BATTERY_MIN_LEN);
        o_stat.rd_last    = (8'(r_ridx) == r_len - 8'd1);
        o_stat.volt_done  = (r_ridx == VOLT_LAST_IDX);
        o_stat.out_free   = out_free;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deliver <= 1'b0;
        end else if (i_cfg_we) begin
            r_deliver <= i_cfg_data;
        end
    end

    // frame fields and checksum sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= '0;
            r_len   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_widx  <= '0;
        end else if (i_cmd.ld_type) begin
            r_type  <= i_rx_byte;
            r_sum_a <= i_rx_byte;
            r_sum_b <= i_rx_byte;
        end else if (i_cmd.ld_len) begin
            r_len   <= i_rx_byte;
            r_sum_a <= fold_a;
            r_sum_b <= r_sum_b + fold_a;
            r_widx  <= '0;
        end else if (i_cmd.wr_data) begin
            r_sum_a <= fold_a;
            r_sum_b <= r_sum_b + fold_a;
            r_widx  <= r_widx + WI_W'(1);
        end
    end

    // payload store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_data) begin
            r_mem[r_widx[PL_AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_ridx];
        end
    end

    // read index
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.rd_clr) begin
            r_ridx <= '0;
        end else if (i_cmd.rd_set1) begin
            r_ridx <= PL_AW'(1);
        end else if (i_cmd.rd_inc) begin
            r_ridx <= r_ridx + PL_AW'(1);
        end
    end

    // voltage word, little-endian assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd.volt_shift) begin
            r_volt <= {r_rd_data, r_volt[31:8]};
        end
    end

    // good-frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 32'd1;
        end
    end

    // output item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.ld_radio || i_cmd.ld_battery) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_radio) begin
            r_o_kind  <= KIND_RADIO;
            r_o_data  <= r_rd_data;
            r_o_volt  <= '0;
            r_o_last  <= o_stat.rd_last;
            r_o_count <= r_count;
        end else if (i_cmd.ld_battery) begin
            r_o_kind  <= KIND_BATTERY;
            r_o_data  <= '0;
            r_o_volt  <= r_volt;
            r_o_last  <= 1'b1;
            r_o_count <= r_count;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_data_byte    = r_o_data;
    assign o_voltage_bits = r_o_volt;
    assign o_last         = r_o_last;
    assign o_good_frames  = r_o_count;

endmodule

[hw/rtl/framed_packet_receiver_fletcher8_core.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_fletcher8_core
// Framed byte receiver with Fletcher-8 check and payload/voltage delivery.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one received byte per
//   item. The parser takes a byte in every cycle while it parses a frame.
//   After the second checksum byte of a good frame the block emits results
//   on the output channel (o_out_valid / i_out_stall) and stalls input:
//     radio frame   - with deliver_enable set, one item per payload byte
//                     (store read, output load), o_last on the final byte
//     battery frame - if length is 5 or more, one item (four store reads
//                     assembled into the voltage word, then output load)
//   Every store read goes through the single registered read port, which
//   sets the emission rate; input resumes in the cycle after the last result
//   is loaded into the output register.
//   When the receiver stalls, the output register holds its item and the
//   sequencer waits; nothing is dropped.
//   i_cfg_we / i_cfg_data write deliver_enable; write only while idle.
//   Reset (i_rst_n low, synchronous) returns to the start-byte hunt, clears
//   the good-frame count and deliver_enable; no store clearing is needed.
// ----------------------------------------------------------------------------
module framed_packet_receiver_fletcher8_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_voltage_bits,
    output logic        o_last,
    output logic [31:0] o_good_frames
);
    import fpr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // frame controller
    fpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath
    fpr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_voltage_bits (o_voltage_bits),
        .o_last         (o_last),
        .o_good_frames  (o_good_frames)
    );

    // a battery item is always the last of its frame with no data byte
    a_battery_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_BATTERY) |-> o_last && (o_data_byte == 8'd0))
        else $error("battery item malformed");

    // a payload byte item carries no voltage bits
    a_radio_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_RADIO) |-> (o_voltage_bits == 32'd0))
        else $error("radio item carries voltage bits");

    // results are only loaded while input is held off
    a_load_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ld_radio || cmd.ld_battery |-> o_in_stall)
        else $error("result loaded while parsing");

    // the good-frame count only moves on a parsed checksum byte
    a_count_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> i_in_valid && !o_in_stall)
        else $error("frame counted without an input item");

endmodule
